>>> rtl/tcm_pkg.sv
// ----------------------------------------------------------------------------
// tcm_pkg
// Types and constants shared by the tile coordinate map.
// ----------------------------------------------------------------------------
`default_nettype none

package tcm_pkg;

	localparam int Entries        = 64;
	localparam int MaxRectMatches = 64;
	localparam int RectCap        = 256;
	localparam int MatchCap       = (MaxRectMatches < RectCap) ? MaxRectMatches : RectCap;

	localparam int IdxW   = (Entries > 1) ? $clog2(Entries) : 1;
	localparam int CntW   = $clog2(Entries + 1);
	localparam int MatchW = $clog2(MatchCap + 1);

	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_RECT   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_BAD_ARG   = 2'd3;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic [31:0]        rect_width;
		logic [31:0]        rect_height;
		logic [31:0]        tile_handle_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [31:0] tile_handle_out;
		logic        last;
	} rsp_t;

endpackage

`default_nettype wire

>>> rtl/tile_coordinate_map.sv
// tile_coordinate_map: lookup / insert / rectangle query over one entry memory
// lookup and insert: scan up from slot 0 to a key match or the last entry
// rect query: one entry read per cycle from the newest entry down, unless stalled
// a match leaves when the next match or scan end is known; held output may stall the scan
// bad argument skips the scan; next request is taken after the last result loads
// reset clears the entry count and control state; memory contents are left as they are
// ----------------------------------------------------------------------------
// tile_coordinate_map
// Map from signed tile coordinates to tile handles with rectangle query.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_coordinate_map (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire tcm_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output tcm_pkg::rsp_t      rsp
);

	typedef struct packed {
		logic signed [31:0] col;
		logic signed [31:0] row;
		logic [31:0]        tile;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	entry_t entry_mem [tcm_pkg::Entries];

	state_t                     state_q;
	logic [1:0]                 kind_q;
	logic signed [31:0]         x_q, y_q, xhi_q, yhi_q;
	logic [31:0]                tile_q;
	logic [tcm_pkg::IdxW-1:0]   ptr_q;
	logic [tcm_pkg::CntW-1:0]   left_q;
	logic [tcm_pkg::CntW-1:0]   count_q;
	logic                       chk_s1;
	logic [tcm_pkg::IdxW-1:0]   idx_s1;
	entry_t                     rdata_s1;
	logic                       pend_v_q;
	logic [31:0]                pend_tile_q;
	logic [tcm_pkg::MatchW-1:0] mcnt_q;
	tcm_pkg::rsp_t              res_q;
	logic                       out_v_q;
	tcm_pkg::rsp_t              out_q;

	logic                     is_rect;
	logic                     key_hit, rect_hit;
	logic                     out_free, stall, issue, scan_end, full;
	logic                     wr_en;
	logic [tcm_pkg::IdxW-1:0] wr_addr;
	logic [31:0]              xhi_in, yhi_in;
	logic [tcm_pkg::CntW-1:0] count_m1;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	assign is_rect  = (kind_q == tcm_pkg::KIND_RECT);
	assign key_hit  = (rdata_s1.col == x_q) && (rdata_s1.row == y_q);
	assign rect_hit = (rdata_s1.col >= x_q) && (rdata_s1.col < xhi_q) &&
	                  (rdata_s1.row >= y_q) && (rdata_s1.row < yhi_q);
	assign out_free = !out_v_q || rsp_ready;
	// an older pending match must leave before a newer one replaces it
	assign stall    = chk_s1 && is_rect && rect_hit && pend_v_q && !out_free;
	assign issue    = (state_q == S_SCAN) && (left_q != '0) && !stall;
	assign scan_end = (state_q == S_SCAN) && (left_q == '0) && !chk_s1;
	assign full     = (count_q >= tcm_pkg::CntW'(tcm_pkg::Entries));

	assign xhi_in   = req.coord_x + req.rect_width;
	assign yhi_in   = req.coord_y + req.rect_height;
	assign count_m1 = count_q - tcm_pkg::CntW'(1);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[tcm_pkg::IdxW-1:0];
		if (state_q == S_SCAN && chk_s1 && kind_q == tcm_pkg::KIND_INSERT && key_hit) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1;
		end else if (scan_end && kind_q == tcm_pkg::KIND_INSERT && !full) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= '{col: x_q, row: y_q, tile: tile_q};
		end
		if (issue) begin
			rdata_s1 <= entry_mem[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= tcm_pkg::KIND_LOOKUP;
			x_q         <= '0;
			y_q         <= '0;
			xhi_q       <= '0;
			yhi_q       <= '0;
			tile_q      <= '0;
			ptr_q       <= '0;
			left_q      <= '0;
			count_q     <= '0;
			chk_s1      <= 1'b0;
			idx_s1      <= '0;
			pend_v_q    <= 1'b0;
			pend_tile_q <= '0;
			mcnt_q      <= '0;
			res_q       <= '0;
			out_v_q     <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_v_q && rsp_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						kind_q   <= req.kind;
						x_q      <= req.coord_x;
						y_q      <= req.coord_y;
						xhi_q    <= $signed(xhi_in);
						yhi_q    <= $signed(yhi_in);
						tile_q   <= req.tile_handle_in;
						pend_v_q <= 1'b0;
						mcnt_q   <= '0;
						chk_s1   <= 1'b0;
						left_q   <= count_q;
						if (req.kind == tcm_pkg::KIND_RECT) begin
							ptr_q <= count_m1[tcm_pkg::IdxW-1:0];
						end else begin
							ptr_q <= '0;
						end
						if (req.kind != tcm_pkg::KIND_LOOKUP && req.kind != tcm_pkg::KIND_INSERT &&
						    req.kind != tcm_pkg::KIND_RECT) begin
							res_q   <= '{status: tcm_pkg::ST_BAD_ARG, found: 1'b0,
							             tile_handle_out: '0, last: 1'b1};
							state_q <= S_FINISH;
						end else if (req.kind == tcm_pkg::KIND_INSERT &&
						             req.tile_handle_in == '0) begin
							res_q   <= '{status: tcm_pkg::ST_BAD_ARG, found: 1'b0,
							             tile_handle_out: '0, last: 1'b1};
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// read stage
					if (issue) begin
						ptr_q  <= is_rect ? ptr_q - 1'b1 : ptr_q + 1'b1;
						left_q <= left_q - 1'b1;
						idx_s1 <= ptr_q;
						chk_s1 <= 1'b1;
					end else if (!stall) begin
						chk_s1 <= 1'b0;
					end
					// check stage
					if (chk_s1 && !stall) begin
						if (!is_rect && key_hit) begin
							chk_s1  <= 1'b0;
							state_q <= S_FINISH;
							if (kind_q == tcm_pkg::KIND_LOOKUP) begin
								res_q <= '{status: tcm_pkg::ST_OK, found: 1'b1,
								           tile_handle_out: rdata_s1.tile, last: 1'b1};
							end else begin
								res_q <= '{status: tcm_pkg::ST_OK, found: 1'b0,
								           tile_handle_out: '0, last: 1'b1};
							end
						end else if (is_rect && rect_hit) begin
							if (pend_v_q) begin
								out_v_q <= 1'b1;
								out_q   <= '{status: tcm_pkg::ST_OK, found: 1'b1,
								             tile_handle_out: pend_tile_q, last: 1'b0};
							end
							pend_v_q    <= 1'b1;
							pend_tile_q <= rdata_s1.tile;
							mcnt_q      <= mcnt_q + 1'b1;
							// match cap reached: this one closes the transaction
							if (mcnt_q + 1'b1 == tcm_pkg::MatchW'(tcm_pkg::MatchCap)) begin
								chk_s1   <= 1'b0;
								pend_v_q <= 1'b0;
								res_q    <= '{status: tcm_pkg::ST_OK, found: 1'b1,
								              tile_handle_out: rdata_s1.tile, last: 1'b1};
								state_q  <= S_FINISH;
							end
						end
					end
					if (scan_end) begin
						state_q  <= S_FINISH;
						pend_v_q <= 1'b0;
						if (kind_q == tcm_pkg::KIND_INSERT) begin
							res_q <= '{status: full ? tcm_pkg::ST_FULL : tcm_pkg::ST_OK,
							           found: 1'b0, tile_handle_out: '0, last: 1'b1};
							if (!full) begin
								count_q <= count_q + 1'b1;
							end
						end else if (is_rect && pend_v_q) begin
							res_q <= '{status: tcm_pkg::ST_OK, found: 1'b1,
							           tile_handle_out: pend_tile_q, last: 1'b1};
						end else begin
							res_q <= '{status: tcm_pkg::ST_NOT_FOUND, found: 1'b0,
							           tile_handle_out: '0, last: 1'b1};
						end
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tcm_pkg::CntW'(tcm_pkg::Entries))
		else $error("entry count above table size");

	a_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SCAN) && (kind_q == tcm_pkg::KIND_INSERT))
		else $error("memory write outside an insert scan");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1) &&
		($past(state_q) == S_SCAN))
		else $error("entry count moved by other than one append");

	a_match_cap: assert property (@(posedge clk) disable iff (!arst_n)
		mcnt_q <= tcm_pkg::MatchW'(tcm_pkg::MatchCap))
		else $error("rect match count above cap");

endmodule

`default_nettype wire
